// ===== src/madt_entry_parser_assert.svh =====
// Assertion macros for the MADT entry parser checker.
`ifndef MADT_ENTRY_PARSER_ASSERT_SVH
`define MADT_ENTRY_PARSER_ASSERT_SVH
// Implication checked each clock, disabled during reset.
`define MADT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define MADT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/madt_pkg.sv =====
// Types and constants shared by the MADT entry parser files.
package madt_pkg;
	localparam int MaxCpus    = 32;
	localparam int MaxIoapics = 8;
	localparam int IsaIrqs    = 16;
	localparam int CpuIdxW    = $clog2(MaxCpus);
	localparam int IoIdxW     = $clog2(MaxIoapics);
	localparam int CpuCntW    = $clog2(MaxCpus + 1);
	localparam int IoCntW     = $clog2(MaxIoapics + 1);
	localparam int RecKeep    = 12;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [7:0] REC_LAPIC   = 8'd0;
	localparam logic [7:0] REC_IOAPIC  = 8'd1;
	localparam logic [7:0] REC_OVERRIDE = 8'd2;
	localparam logic [7:0] REC_X2APIC  = 8'd9;
	localparam logic [1:0] FLAG_ALL    = 2'h3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic [4:0] query_index;
		logic [7:0] query_irq;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  cpu_count;
		logic [31:0] boot_cpu_id;
		logic [31:0] cpu_apic_id;
		logic        cpu_usable;
		logic [3:0]  ioapic_count;
		logic [31:0] ioapic_addr;
		logic [31:0] ioapic_irq_base;
		logic [31:0] irq_gsi;
		logic        irq_level_trigger;
		logic        irq_active_low;
		logic        irq_overridden;
		logic        parse_stopped;
	} out_item_t;

	typedef struct packed {
		logic [31:0] id;
		logic        usable;
	} cpu_ent_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] irq_base;
	} io_ent_t;

	typedef struct packed {
		logic [31:0] gsi;
		logic        level;
		logic        low;
	} route_t;
endpackage

// ===== src/madt_ram.sv =====
// Generic single-port-write, one-read RAM with registered, enabled read data.
module madt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/madt_entry_parser.sv =====
// MADT entry parser top level: record assembler, table memories, query port.
// A query result is registered and valid in the cycle after the query is accepted.
// Throughput: one transaction per cycle; any input stalls while a result sits
// in the output register and is not taken in that cycle.
// Reset: arst_n clears counts, route valid bits, assembler state and region_q;
// the table memories keep whatever they hold and are read only below their counts.
module madt_entry_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  madt_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output madt_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);
	import madt_pkg::*;

	logic [15:0] region_q;
	logic [7:0]  rec_q [RecKeep];
	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [15:0] consumed_q;
	logic        stopped_q;
	logic [CpuCntW-1:0] cpu_total_q;
	logic [IoCntW-1:0]  io_total_q;
	logic [31:0] boot_id_q;
	// Override routes: small register file with valid (overridden) bits.
	route_t      route_q [IsaIrqs];
	logic [IsaIrqs-1:0] ovr_q;

	// Output stage.
	logic        out_valid_s1;
	logic        cpu_hit_s1, io_hit_s1;
	out_item_t   res_s1;

	logic take, is_byte, is_start, is_query;
	assign cfg_ready = 1'b1;
	// Results drain from one register; stall input only while it is full.
	assign in_ready  = !out_valid_s1 || out_ready;
	assign take      = in_valid && in_ready;
	assign is_start  = take && in_data.action == ACT_START;
	assign is_byte   = take && in_data.action == ACT_BYTE;
	assign is_query  = take && in_data.action == ACT_QUERY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else if (cfg_valid) begin
			region_q <= cfg_data;
		end
	end

	// Record assembler: the byte being taken is merged into a view of the record.
	logic        byte_ok;
	logic [7:0]  pos_inc;
	logic [7:0]  rv [RecKeep];
	logic [16:0] end_sum;
	logic        hdr_bad, rec_done;
	logic [7:0]  rlen;

	assign byte_ok = is_byte && !stopped_q && (consumed_q < region_q);
	assign pos_inc = pos_q + 8'd1;
	assign rlen    = (pos_inc == 8'd2) ? in_data.data_byte : len_q;
	assign end_sum = {1'b0, consumed_q} - 17'd1 + {9'd0, in_data.data_byte};
	assign hdr_bad = (pos_inc == 8'd2) &&
		(in_data.data_byte < 8'd2 || end_sum > {1'b0, region_q});
	assign rec_done = byte_ok && !hdr_bad && pos_inc >= 8'd2 && pos_inc == rlen;

	always_comb begin
		for (int i = 0; i < RecKeep; i++) begin
			// Bytes at or past record length read as zero.
			if (i >= rlen) rv[i] = 8'd0;
			else if (pos_q == 8'(i)) rv[i] = in_data.data_byte;
			else rv[i] = rec_q[i];
		end
	end

	logic [31:0] u4, u8;
	assign u4 = {rv[7], rv[6], rv[5], rv[4]};
	assign u8 = {rv[11], rv[10], rv[9], rv[8]};

	logic        cpu_add, io_add, ovr_add;
	logic [31:0] cpu_id_w;
	logic        cpu_use_w;
	always_comb begin
		cpu_add = 1'b0;
		cpu_id_w = 32'd0;
		cpu_use_w = 1'b0;
		io_add = 1'b0;
		ovr_add = 1'b0;
		if (rec_done) begin
			if (rv[0] == REC_LAPIC) begin
				cpu_add = cpu_total_q < CpuCntW'(MaxCpus);
				cpu_id_w = {24'd0, rv[3]};
				cpu_use_w = |rv[4][1:0];
			end else if (rv[0] == REC_X2APIC) begin
				cpu_add = cpu_total_q < CpuCntW'(MaxCpus);
				cpu_id_w = u4;
				cpu_use_w = |rv[8][1:0];
			end else if (rv[0] == REC_IOAPIC) begin
				io_add = io_total_q < IoCntW'(MaxIoapics);
			end else if (rv[0] == REC_OVERRIDE) begin
				ovr_add = rv[2] == 8'd0 && rv[3] < 8'(IsaIrqs);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			consumed_q <= '0;
			stopped_q <= 1'b0;
			cpu_total_q <= '0;
			io_total_q <= '0;
			ovr_q <= '0;
		end else if (is_start) begin
			pos_q <= '0;
			len_q <= '0;
			consumed_q <= '0;
			stopped_q <= 1'b0;
			cpu_total_q <= '0;
			io_total_q <= '0;
			ovr_q <= '0;
		end else if (byte_ok) begin
			consumed_q <= consumed_q + 16'd1;
			if (hdr_bad) begin
				stopped_q <= 1'b1;
				pos_q <= pos_inc;
			end else begin
				pos_q <= rec_done ? 8'd0 : pos_inc;
			end
			if (pos_inc == 8'd2) len_q <= in_data.data_byte;
			if (cpu_add) cpu_total_q <= cpu_total_q + 1'b1;
			if (io_add) io_total_q <= io_total_q + 1'b1;
			if (ovr_add) ovr_q[rv[3][3:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			for (int i = 0; i < RecKeep; i++) rec_q[i] <= 8'd0;
		end else if (byte_ok && pos_q < 8'(RecKeep)) begin
			rec_q[pos_q[3:0]] <= in_data.data_byte;
		end
		if (ovr_add) begin
			route_q[rv[3][3:0]] <= '{gsi: u4,
				level: rv[8][3:2] == FLAG_ALL, low: rv[8][1:0] == FLAG_ALL};
		end
		if (cpu_add && cpu_total_q == '0) boot_id_q <= cpu_id_w;
	end

	// Table memories; reads issue on the query and land in the output cycle.
	// Read data holds until the next query, so a stalled result stays put.
	cpu_ent_t cpu_rd;
	io_ent_t  io_rd;
	madt_ram #(.Width($bits(cpu_ent_t)), .Depth(MaxCpus)) u_cpu_ram (
		.clk  (clk),
		.we   (cpu_add),
		.waddr(cpu_total_q[CpuIdxW-1:0]),
		.wdata({cpu_id_w, cpu_use_w}),
		.re   (is_query),
		.raddr(in_data.query_index[CpuIdxW-1:0]),
		.rdata(cpu_rd)
	);
	madt_ram #(.Width($bits(io_ent_t)), .Depth(MaxIoapics)) u_io_ram (
		.clk  (clk),
		.we   (io_add),
		.waddr(io_total_q[IoIdxW-1:0]),
		.wdata({u4, u8}),
		.re   (is_query),
		.raddr(in_data.query_index[IoIdxW-1:0]),
		.rdata(io_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			out_valid_s1 <= is_query;
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			cpu_hit_s1 <= {1'b0, in_data.query_index} < 6'(cpu_total_q);
			io_hit_s1  <= 5'(in_data.query_index) < 5'(io_total_q);
			res_s1.cpu_count <= 6'(cpu_total_q);
			res_s1.boot_cpu_id <= (cpu_total_q != '0) ? boot_id_q : 32'd0;
			// Table fields come straight from the memories at the output.
			res_s1.cpu_apic_id <= '0;
			res_s1.cpu_usable <= 1'b0;
			res_s1.ioapic_addr <= '0;
			res_s1.ioapic_irq_base <= '0;
			res_s1.ioapic_count <= 4'(io_total_q);
			res_s1.parse_stopped <= stopped_q;
			if (in_data.query_irq < 8'(IsaIrqs) && ovr_q[in_data.query_irq[3:0]]) begin
				res_s1.irq_gsi <= route_q[in_data.query_irq[3:0]].gsi;
				res_s1.irq_level_trigger <= route_q[in_data.query_irq[3:0]].level;
				res_s1.irq_active_low <= route_q[in_data.query_irq[3:0]].low;
				res_s1.irq_overridden <= 1'b1;
			end else begin
				res_s1.irq_gsi <= {24'd0, in_data.query_irq};
				res_s1.irq_level_trigger <= 1'b0;
				res_s1.irq_active_low <= 1'b0;
				res_s1.irq_overridden <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_s1;
	always_comb begin
		out_data = res_s1;
		out_data.cpu_apic_id = cpu_hit_s1 ? cpu_rd.id : 32'd0;
		out_data.cpu_usable = cpu_hit_s1 && cpu_rd.usable;
		out_data.ioapic_addr = io_hit_s1 ? io_rd.address : 32'd0;
		out_data.ioapic_irq_base = io_hit_s1 ? io_rd.irq_base : 32'd0;
	end
endmodule

// ===== src/madt_chk.sv =====
// Port-level checker for the MADT entry parser, bound to the top level.
`include "madt_entry_parser_assert.svh"
module madt_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input madt_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input madt_pkg::out_item_t out_data
);
	import madt_pkg::*;
	`MADT_ASSERT_IMP(a_cnt_cpu, out_valid, out_data.cpu_count <= 6'(MaxCpus),
		"cpu count out of range")
	`MADT_ASSERT_IMP(a_cnt_io, out_valid, out_data.ioapic_count <= 4'(MaxIoapics),
		"ioapic count out of range")
	`MADT_ASSERT_NXT(a_query_res, in_valid && in_ready && in_data.action == ACT_QUERY,
		out_valid, "query produced no result")
	`MADT_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data),
		"stalled result changed")
endmodule

bind madt_entry_parser madt_chk u_chk (.*);

// ===== verif/madt_entry_parser_test.sv =====
// Self-checking testbench for the MADT entry parser: record stream, tables, queries.
`timescale 1ns / 1ps
module madt_entry_parser_test;
	import madt_pkg::*;

	localparam int MaxCycles = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	madt_entry_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Predictor of the table parser plus the queue of pending query answers.
	class madt_scoreboard;
		logic [15:0] region_len;
		logic [7:0] rec_buf [RecKeep];
		int unsigned rec_pos;
		int unsigned rec_len;
		int unsigned consumed;
		bit stopped;
		logic [31:0] cpu_id [MaxCpus];
		bit cpu_ok [MaxCpus];
		int unsigned cpu_cnt;
		logic [31:0] io_addr [MaxIoapics];
		logic [31:0] io_base [MaxIoapics];
		int unsigned io_cnt;
		logic [31:0] rt_gsi [IsaIrqs];
		bit rt_level [IsaIrqs];
		bit rt_low [IsaIrqs];
		bit rt_ovr [IsaIrqs];
		out_item_t answers [$];
		int errors;

		function new();
			region_len = 0;
			errors = 0;
			clear_tables();
		endfunction

		function void clear_tables();
			for (int i = 0; i < RecKeep; i++) rec_buf[i] = 0;
			rec_pos = 0;
			rec_len = 0;
			consumed = 0;
			stopped = 0;
			cpu_cnt = 0;
			io_cnt = 0;
			for (int i = 0; i < IsaIrqs; i++) begin
				rt_gsi[i] = i;
				rt_level[i] = 0;
				rt_low[i] = 0;
				rt_ovr[i] = 0;
			end
		endfunction

		// Bytes past the record's length read as zero.
		function logic [7:0] fb(int unsigned i);
			if (i >= rec_len || i >= RecKeep) return 8'd0;
			return rec_buf[i];
		endfunction

		function logic [31:0] fw(int unsigned i);
			return {fb(i + 3), fb(i + 2), fb(i + 1), fb(i)};
		endfunction

		function void add_cpu(logic [31:0] id, logic [31:0] flags);
			if (cpu_cnt >= MaxCpus) return;
			cpu_id[cpu_cnt] = id;
			cpu_ok[cpu_cnt] = flags[0] | flags[1];
			cpu_cnt++;
		endfunction

		function void close_record();
			logic [7:0] kind;
			logic [7:0] src;
			logic [15:0] fl;
			kind = fb(0);
			if (kind == REC_LAPIC) add_cpu({24'd0, fb(3)}, fw(4));
			else if (kind == REC_X2APIC) add_cpu(fw(4), fw(8));
			else if (kind == REC_IOAPIC) begin
				if (io_cnt < MaxIoapics) begin
					io_addr[io_cnt] = fw(4);
					io_base[io_cnt] = fw(8);
					io_cnt++;
				end
			end else if (kind == REC_OVERRIDE) begin
				src = fb(3);
				fl = {fb(9), fb(8)};
				if (fb(2) == 0 && src < IsaIrqs) begin
					rt_gsi[src] = fw(4);
					rt_ovr[src] = 1;
					rt_low[src] = fl[1:0] == FLAG_ALL;
					rt_level[src] = fl[3:2] == FLAG_ALL;
				end
			end
		endfunction

		function void take_byte(logic [7:0] b);
			if (stopped || consumed >= region_len) return;
			if (rec_pos < RecKeep) rec_buf[rec_pos] = b;
			rec_pos++;
			consumed++;
			if (rec_pos == 2) begin
				rec_len = rec_buf[1];
				if (rec_len < 2 || consumed - 2 + rec_len > region_len) begin
					stopped = 1;
					return;
				end
			end
			if (rec_pos >= 2 && rec_pos == rec_len) begin
				close_record();
				rec_pos = 0;
			end
		endfunction

		// Note one accepted input transaction.
		function void note_input(in_item_t it);
			out_item_t r;
			case (action_t'(it.action))
				ACT_START: clear_tables();
				ACT_BYTE: take_byte(it.data_byte);
				ACT_QUERY: begin
					r = '0;
					r.cpu_count = 6'(cpu_cnt);
					r.boot_cpu_id = cpu_cnt > 0 ? cpu_id[0] : 32'd0;
					if (it.query_index < cpu_cnt) begin
						r.cpu_apic_id = cpu_id[it.query_index];
						r.cpu_usable = cpu_ok[it.query_index];
					end
					r.ioapic_count = 4'(io_cnt);
					if (it.query_index < io_cnt) begin
						r.ioapic_addr = io_addr[it.query_index];
						r.ioapic_irq_base = io_base[it.query_index];
					end
					if (it.query_irq < IsaIrqs) begin
						r.irq_gsi = rt_gsi[it.query_irq];
						r.irq_level_trigger = rt_level[it.query_irq];
						r.irq_active_low = rt_low[it.query_irq];
						r.irq_overridden = rt_ovr[it.query_irq];
					end else begin
						r.irq_gsi = {24'd0, it.query_irq};
					end
					r.parse_stopped = stopped;
					answers.push_back(r);
				end
				default: ;
			endcase
		endfunction

		// Check one accepted result transaction against the oldest answer.
		function void check_result(out_item_t got);
			out_item_t exp;
			if (answers.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = answers.pop_front();
			if (got.cpu_count !== exp.cpu_count) report("cpu_count", exp.cpu_count, got.cpu_count);
			if (got.boot_cpu_id !== exp.boot_cpu_id)
				report("boot_cpu_id", exp.boot_cpu_id, got.boot_cpu_id);
			if (got.cpu_apic_id !== exp.cpu_apic_id)
				report("cpu_apic_id", exp.cpu_apic_id, got.cpu_apic_id);
			if (got.cpu_usable !== exp.cpu_usable)
				report("cpu_usable", exp.cpu_usable, got.cpu_usable);
			if (got.ioapic_count !== exp.ioapic_count)
				report("ioapic_count", exp.ioapic_count, got.ioapic_count);
			if (got.ioapic_addr !== exp.ioapic_addr)
				report("ioapic_addr", exp.ioapic_addr, got.ioapic_addr);
			if (got.ioapic_irq_base !== exp.ioapic_irq_base)
				report("ioapic_irq_base", exp.ioapic_irq_base, got.ioapic_irq_base);
			if (got.irq_gsi !== exp.irq_gsi) report("irq_gsi", exp.irq_gsi, got.irq_gsi);
			if (got.irq_level_trigger !== exp.irq_level_trigger)
				report("irq_level_trigger", exp.irq_level_trigger, got.irq_level_trigger);
			if (got.irq_active_low !== exp.irq_active_low)
				report("irq_active_low", exp.irq_active_low, got.irq_active_low);
			if (got.irq_overridden !== exp.irq_overridden)
				report("irq_overridden", exp.irq_overridden, got.irq_overridden);
			if (got.parse_stopped !== exp.parse_stopped)
				report("parse_stopped", exp.parse_stopped, got.parse_stopped);
		endfunction

		function void report(string field, logic [31:0] exp, logic [31:0] got);
			$display("%0t: %s expected %h actual %h", $time, field, exp, got);
			errors++;
		endfunction
	endclass

	madt_scoreboard sb;
	int cycle_count = 0;
	bit sender_calm;    // no random gaps on the sender
	bit receiver_calm;  // no random stalls on the receiver
	bit hold_off;       // receiver parked for a long stretch

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: cycle count limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MaxCycles) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Scoreboard taps on both handshakes.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Receiver: random stalls, except during calm stretches or a hold-off.
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else if (hold_off) out_ready <= 1'b0;
		else out_ready <= receiver_calm || ($urandom_range(99) >= 36);
	end

	// Send one input transaction, with a random gap before it unless the sender is calm.
	task automatic send(logic [1:0] act, logic [7:0] b, logic [4:0] idx, logic [7:0] irq);
		in_item_t it;
		it.action = act;
		it.data_byte = b;
		it.query_index = idx;
		it.query_irq = irq;
		if (!sender_calm) begin
			while ($urandom_range(99) < 36) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		send(ACT_BYTE, b, 5'($urandom_range(31)), 8'($urandom_range(255)));
	endtask

	task automatic query(logic [4:0] idx, logic [7:0] irq);
		send(ACT_QUERY, 8'($urandom_range(255)), idx, irq);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every answer is taken, then let the block settle.
	task automatic drain();
		drop_valid();
		while (sb.answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_region(logic [15:0] len);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.region_len = len;
		@(posedge clk);
	endtask

	task automatic send_u32(logic [31:0] v);
		for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8]);
	endtask

	// One record: type, length, then len-2 body bytes (random filler unless given).
	task automatic send_record(logic [7:0] kind, logic [7:0] len, logic [7:0] body [$]);
		send_byte(kind);
		send_byte(len);
		for (int i = 2; i < len; i++)
			send_byte(i - 2 < body.size() ? body[i - 2] : 8'($urandom_range(255)));
	endtask

	// Random well-formed record with plausible content.
	task automatic random_record();
		logic [7:0] body [$];
		logic [7:0] kind;
		logic [7:0] len;
		int pick;
		pick = $urandom_range(9);
		body = {};
		case (pick)
			0, 1, 2: begin
				kind = REC_LAPIC;
				len = $urandom_range(3) == 0 ? 8'($urandom_range(2, 10)) : 8'd8;
				body = {8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(3)), 8'd0, 8'd0, 8'd0};
			end
			3, 4: begin
				kind = REC_X2APIC;
				len = $urandom_range(3) == 0 ? 8'($urandom_range(2, 16)) : 8'd16;
			end
			5, 6: begin
				kind = REC_IOAPIC;
				len = $urandom_range(3) == 0 ? 8'($urandom_range(2, 14)) : 8'd12;
			end
			7, 8: begin
				kind = REC_OVERRIDE;
				len = $urandom_range(3) == 0 ? 8'($urandom_range(2, 12)) : 8'd10;
				body = {($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'd0,
					($urandom_range(5) == 0) ? 8'($urandom_range(255))
						: 8'($urandom_range(15)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255))};
			end
			default: begin
				kind = 8'($urandom_range(255));
				len = 8'($urandom_range(2, 20));
			end
		endcase
		send_record(kind, len, body);
	endtask

	// One table: start, records until n_bytes are counted as sent, queries mixed in.
	task automatic random_table(int n_bytes);
		int sent;
		send(ACT_START, 8'($urandom_range(255)), 5'($urandom_range(31)),
			8'($urandom_range(255)));
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(9) == 0) begin
				query(5'($urandom_range(31)), $urandom_range(3) == 0
					? 8'($urandom_range(255)) : 8'($urandom_range(15)));
			end else if ($urandom_range(29) == 0) begin
				send_byte(8'($urandom_range(255)));  // noise that may break framing
				sent++;
			end else if ($urandom_range(49) == 0) begin
				send(ACT_NONE, 8'($urandom_range(255)), 5'($urandom_range(31)),
					8'($urandom_range(255)));
			end else begin
				random_record();
				sent += 8;
			end
		end
		for (int i = 0; i < 6; i++) query(5'($urandom_range(31)), 8'($urandom_range(255)));
	endtask

	initial begin
		logic [7:0] empty [$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_ready = 1'b0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		hold_off = 1'b0;
		empty = {};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: region length zero ignores all bytes.
		query(0, 0);
		send_record(REC_LAPIC, 8, {8'd1, 8'd5, 8'd1, 8'd0, 8'd0, 8'd0});
		query(31, 255);
		drain();

		write_region(16'hFFFF);
		send(ACT_START, 0, 0, 0);
		send_record(REC_LAPIC, 8, {8'hFF, 8'hFF, 8'd2, 8'd0, 8'd0, 8'd0});
		send_record(REC_X2APIC, 16, {8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'd0, 8'd0, 8'd0, 8'd0});
		send_record(REC_IOAPIC, 12, {8'h7, 8'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_record(REC_OVERRIDE, 10, {8'd0, 8'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h0F, 8'h00});
		send_record(REC_IOAPIC, 5, {8'h1, 8'h0, 8'hAA});  // short record
		send_record(8'hEE, 20, empty);                      // long unknown record
		query(1, 15);
		query(2, 16);
		query(1, 0);
		send_record(REC_LAPIC, 1, empty);                   // bad length stops parse
		query(0, 15);
		drain();

		// Record running past the region end, then a lone trailing byte.
		write_region(16'd10);
		send(ACT_START, 0, 0, 0);
		send_record(REC_LAPIC, 8, {8'd3, 8'd9, 8'd1, 8'd0, 8'd0, 8'd0});
		send_byte(REC_LAPIC);
		send_byte(8'd8);
		query(0, 3);
		drain();
		write_region(16'd9);
		write_region(16'd9);
		send(ACT_START, 0, 0, 0);
		send_record(REC_LAPIC, 8, {8'd3, 8'd9, 8'd0, 8'd0, 8'd0, 8'd0});
		send_byte(8'h55);
		query(0, 200);
		drain();

		// Fill the processor and controller tables past their limits.
		write_region(16'hFFFF);
		send(ACT_START, 0, 0, 0);
		for (int i = 0; i < MaxCpus + 2; i++)
			send_record(REC_LAPIC, 8, {i[7:0], i[7:0], 8'd1, 8'd0, 8'd0, 8'd0});
		for (int i = 0; i < MaxIoapics + 2; i++) send_record(REC_IOAPIC, 12, empty);
		for (int i = 0; i < 32; i++) query(5'(i), 8'(i));
		drain();

		// Pressure: receiver parked while the sender keeps pushing queries.
		sender_calm = 1'b1;
		hold_off <= 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off <= 1'b0;
			end
			for (int i = 0; i < 20; i++)
				query(5'($urandom_range(31)), 8'($urandom_range(255)));
		join
		drain();
		sender_calm = 1'b0;

		// Random tables across several region lengths; a calm stretch in the middle.
		for (int t = 0; t < 15; t++) begin
			case (t % 5)
				0: write_region(16'hFFFF);
				1: write_region(16'($urandom_range(20, 120)));
				2: write_region(16'd0);
				default: write_region(16'($urandom_range(40, 300)));
			endcase
			sender_calm = (t >= 6 && t < 9);
			receiver_calm <= sender_calm;
			random_table($urandom_range(20, 80));
			drain();  // sender waits for every answer before the next setting
		end
		sender_calm = 1'b0;
		receiver_calm <= 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.answers.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
